### design/lkpc_pkg.sv
// ----------------------------------------------------------------------------
// lkpc_pkg
// Types, codes and reset values shared by the ladder keypad player control.
// ----------------------------------------------------------------------------
package lkpc_pkg;

  localparam int SONG_COUNT = 16;
  localparam int NUM_KEYS   = 5;

  localparam logic [4:0] VOL_MAX   = 5'd30;
  localparam logic [4:0] VOL_RESET = 5'd15;

  localparam logic [11:0] LEVEL_SELECT_RESET   = 12'd100;
  localparam logic [11:0] LEVEL_DOWN_RESET     = 12'd300;
  localparam logic [11:0] LEVEL_UP_RESET       = 12'd500;
  localparam logic [11:0] LEVEL_VOL_UP_RESET   = 12'd700;
  localparam logic [11:0] LEVEL_VOL_DOWN_RESET = 12'd900;
  localparam logic [11:0] WINDOW_HALF_RESET    = 12'd50;
  localparam logic [15:0] SETTLE_MS_RESET      = 16'd50;
  localparam logic [15:0] HOLD_MS_RESET        = 16'd1000;

  typedef enum logic [2:0] {
    KEY_NONE     = 3'd0,
    KEY_SELECT   = 3'd1,
    KEY_DOWN     = 3'd2,
    KEY_UP       = 3'd3,
    KEY_VOL_UP   = 3'd4,
    KEY_VOL_DOWN = 3'd5
  } key_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_PLAY    = 3'd1,
    CMD_RESUME  = 3'd2,
    CMD_PAUSE   = 3'd3,
    CMD_SET_VOL = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LEVEL_SELECT   = 3'd0,
    REG_LEVEL_DOWN     = 3'd1,
    REG_LEVEL_UP       = 3'd2,
    REG_LEVEL_VOL_UP   = 3'd3,
    REG_LEVEL_VOL_DOWN = 3'd4,
    REG_WINDOW_HALF    = 3'd5,
    REG_SETTLE_MS      = 3'd6,
    REG_HOLD_MS        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] sample;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] stable_key;
    logic [2:0] press_event;
    logic       menu_mode;
    logic       playing;
    logic [3:0] list_pos;
    logic [4:0] track_no;
    logic [4:0] vol_level;
    logic [2:0] player_cmd;
    logic       refresh;
  } out_item_t;

endpackage

### design/ladder_key_player_control_top.sv
// ----------------------------------------------------------------------------
// ladder_key_player_control_top
// Resistor-ladder keypad decode, debounce, long press and music player state.
// ----------------------------------------------------------------------------
// Each transaction on the input channel carries one 12-bit ladder ADC sample
// and a free-running millisecond timestamp; each produces exactly one result
// transaction giving the debounced key, any new press, the player mode, cursor,
// song, volume, a player command and a display refresh flag. The block takes
// one transaction per clock cycle when the result side keeps up: the sample is
// classified against the five key windows on entry and held in an input
// register, and the debounce, hold timer and player update run combinationally
// from that register into the result register.
// The result register lets a new sample enter while the last result waits.
// Configuration writes (level centres, window, settle and hold times) take
// effect at once and are to be made only while no transaction is in flight.
// Timestamp differences wrap modulo 2^32; a hold started at time zero reads
// as not running and restarts on the next sample.
// ----------------------------------------------------------------------------
module ladder_key_player_control_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lkpc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lkpc_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_idx,
  input  logic [15:0]          cfg_data
);

  import lkpc_pkg::*;

  // Configuration registers
  logic [11:0] level [NUM_KEYS];
  logic [11:0] window_half;
  logic [15:0] settle_ms;
  logic [15:0] hold_ms;

  // Input register: classified key and timestamp
  logic        stage_valid;
  key_t        stage_raw;
  logic [31:0] stage_now;

  // Keypad and player state
  key_t        prev_raw_key, prev_raw_key_next;
  key_t        debounced_key, debounced_key_next;
  logic [31:0] change_time, change_time_next;
  logic [31:0] hold_start, hold_start_next;
  logic        in_menu, in_menu_next;
  logic        is_playing, is_playing_next;
  logic [4:0]  volume_now, volume_now_next;
  logic [3:0]  cursor_item, cursor_item_next;
  logic [4:0]  song_now, song_now_next;

  logic        accept;
  logic        advance;
  key_t        raw_in;
  logic [NUM_KEYS-1:0] hit;
  logic [11:0] diff [NUM_KEYS];

  key_t        press;
  cmd_t        cmd;
  logic        refresh;
  logic [31:0] settle_elapsed;
  logic [31:0] hold_elapsed;

  // Advance the input register into the result register when the result is
  // free or being taken this cycle.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;
  assign accept   = in_valid && in_ready;

  // Classify: absolute distance to each level centre, first match wins.
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      diff[k] = (in_data.sample >= level[k]) ? (in_data.sample - level[k])
                                             : (level[k] - in_data.sample);
      hit[k]  = diff[k] < window_half;
    end
    if (hit[0]) begin
      raw_in = KEY_SELECT;
    end else if (hit[1]) begin
      raw_in = KEY_DOWN;
    end else if (hit[2]) begin
      raw_in = KEY_UP;
    end else if (hit[3]) begin
      raw_in = KEY_VOL_UP;
    end else if (hit[4]) begin
      raw_in = KEY_VOL_DOWN;
    end else begin
      raw_in = KEY_NONE;
    end
  end

  // Debounce, hold timer and player update for the item in the input register.
  always_comb begin
    prev_raw_key_next  = stage_raw;
    debounced_key_next = debounced_key;
    hold_start_next    = hold_start;
    in_menu_next       = in_menu;
    is_playing_next    = is_playing;
    volume_now_next    = volume_now;
    cursor_item_next   = cursor_item;
    song_now_next      = song_now;
    press              = KEY_NONE;
    cmd                = CMD_NONE;
    refresh            = 1'b0;

    // Restart the settle time whenever the raw key changes
    change_time_next = (stage_raw != prev_raw_key) ? stage_now : change_time;
    settle_elapsed   = stage_now - change_time_next;
    if (settle_elapsed > {16'd0, settle_ms} && stage_raw != debounced_key) begin
      debounced_key_next = stage_raw;
      press              = stage_raw;
    end

    // Long select hold in play mode drops back to the menu
    if (debounced_key_next == KEY_SELECT && !in_menu) begin
      if (hold_start == 32'd0) begin
        hold_start_next = stage_now;
      end
      hold_elapsed = stage_now - hold_start_next;
      if (hold_elapsed > {16'd0, hold_ms}) begin
        in_menu_next    = 1'b1;
        hold_start_next = 32'd0;
        refresh         = 1'b1;
      end
    end else begin
      hold_elapsed    = 32'd0;
      hold_start_next = 32'd0;
    end

    if (in_menu_next) begin
      if (press == KEY_SELECT) begin
        in_menu_next    = 1'b0;
        song_now_next   = {1'b0, cursor_item} + 5'd1;
        is_playing_next = 1'b1;
        cmd             = CMD_PLAY;
        refresh         = 1'b1;
      end else if (press == KEY_DOWN &&
                   ({1'b0, cursor_item} + 5'd1) < 5'(SONG_COUNT)) begin
        cursor_item_next = cursor_item + 4'd1;
        refresh          = 1'b1;
      end else if (press == KEY_UP && cursor_item != 4'd0) begin
        cursor_item_next = cursor_item - 4'd1;
        refresh          = 1'b1;
      end
    end else begin
      if (press == KEY_SELECT) begin
        is_playing_next = !is_playing;
        cmd             = is_playing ? CMD_PAUSE : CMD_RESUME;
        refresh         = 1'b1;
      end else if (press == KEY_DOWN && song_now < 5'(SONG_COUNT)) begin
        song_now_next   = song_now + 5'd1;
        is_playing_next = 1'b1;
        cmd             = CMD_PLAY;
        refresh         = 1'b1;
      end else if (press == KEY_UP && song_now > 5'd1) begin
        song_now_next   = song_now - 5'd1;
        is_playing_next = 1'b1;
        cmd             = CMD_PLAY;
        refresh         = 1'b1;
      end
    end

    // Volume steps in either mode, clamped at both ends
    if (press == KEY_VOL_UP && volume_now < VOL_MAX) begin
      volume_now_next = volume_now + 5'd1;
      cmd             = CMD_SET_VOL;
      refresh         = 1'b1;
    end else if (press == KEY_VOL_DOWN && volume_now != 5'd0) begin
      volume_now_next = volume_now - 5'd1;
      cmd             = CMD_SET_VOL;
      refresh         = 1'b1;
    end
  end

  // Configuration writes, masked to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      level[0]    <= LEVEL_SELECT_RESET;
      level[1]    <= LEVEL_DOWN_RESET;
      level[2]    <= LEVEL_UP_RESET;
      level[3]    <= LEVEL_VOL_UP_RESET;
      level[4]    <= LEVEL_VOL_DOWN_RESET;
      window_half <= WINDOW_HALF_RESET;
      settle_ms   <= SETTLE_MS_RESET;
      hold_ms     <= HOLD_MS_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_LEVEL_SELECT:   level[0]    <= cfg_data[11:0];
        REG_LEVEL_DOWN:     level[1]    <= cfg_data[11:0];
        REG_LEVEL_UP:       level[2]    <= cfg_data[11:0];
        REG_LEVEL_VOL_UP:   level[3]    <= cfg_data[11:0];
        REG_LEVEL_VOL_DOWN: level[4]    <= cfg_data[11:0];
        REG_WINDOW_HALF:    window_half <= cfg_data[11:0];
        REG_SETTLE_MS:      settle_ms   <= cfg_data;
        REG_HOLD_MS:        hold_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: hold the classified sample until it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
    if (accept) begin
      stage_raw <= raw_in;
      stage_now <= in_data.now_ms;
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      prev_raw_key  <= KEY_NONE;
      debounced_key <= KEY_NONE;
      change_time   <= 32'd0;
      hold_start    <= 32'd0;
      in_menu       <= 1'b1;
      is_playing    <= 1'b0;
      volume_now    <= VOL_RESET;
      cursor_item   <= 4'd0;
      song_now      <= 5'd1;
    end else if (advance) begin
      out_valid     <= 1'b1;
      prev_raw_key  <= prev_raw_key_next;
      debounced_key <= debounced_key_next;
      change_time   <= change_time_next;
      hold_start    <= hold_start_next;
      in_menu       <= in_menu_next;
      is_playing    <= is_playing_next;
      volume_now    <= volume_now_next;
      cursor_item   <= cursor_item_next;
      song_now      <= song_now_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data.stable_key  <= debounced_key_next;
      out_data.press_event <= press;
      out_data.menu_mode   <= in_menu_next;
      out_data.playing     <= is_playing_next;
      out_data.list_pos    <= cursor_item_next;
      out_data.track_no    <= song_now_next;
      out_data.vol_level   <= volume_now_next;
      out_data.player_cmd  <= cmd;
      out_data.refresh     <= refresh;
    end
  end

`ifndef SYNTHESIS
  // A press always reports the key that just became stable
  a_press_is_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.press_event != KEY_NONE
      |-> out_data.stable_key == out_data.press_event)
    else $error("press event differs from stable key");

  // Every player command comes with a display refresh
  a_cmd_refresh: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.player_cmd != CMD_NONE |-> out_data.refresh)
    else $error("player command without refresh");

  // Resume and pause are only issued in play mode
  a_menu_no_toggle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.menu_mode
      |-> out_data.player_cmd != CMD_RESUME && out_data.player_cmd != CMD_PAUSE)
    else $error("resume or pause issued in menu");

  // A stalled result with a full input register blocks new samples
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    stage_valid && out_valid && !out_ready |-> !in_ready)
    else $error("sample accepted while pipeline stalled");

  // Volume stays within range after any update
  a_vol_range: assert property (@(posedge clk) disable iff (rst)
    advance |=> volume_now <= VOL_MAX)
    else $error("volume out of range");
`endif

endmodule
